[rtl/ufcm_pkg.sv]
// ---------------------------------------------------------------------------
// ufcm_pkg
// Shared types and constants for the union-find parent table: request
// structs, opcode codes and controller states.
// ---------------------------------------------------------------------------
package ufcm_pkg;

  localparam int VERTEX_W         = 10;
  localparam int OPCODE_W         = 2;
  localparam int NUM_VERTICES_DEF = 1024;

  localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LINK   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;

  typedef logic [VERTEX_W-1:0] vertex_t;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    vertex_t             vertex_a;
    vertex_t             vertex_b;
  } in_req_t;

  typedef struct packed {
    vertex_t result_vertex;
    logic    is_own_root;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIRST,
    ST_WALK,
    ST_HOLD
  } state_t;

endpackage

[rtl/union_find_collapse_map.sv]
// ---------------------------------------------------------------------------
// union_find_collapse_map
// Union-find parent table with path-splitting find, link and lookup.
//
// Requests enter on in_valid/in_stall as in_req (opcode, vertex_a,
// vertex_b); each request gives exactly one result on out_valid/out_stall
// as out_req (result_vertex, is_own_root). One request is worked on at a
// time; in_stall is high while the controller is busy.
// Link and lookup read the parent of vertex_a, then write or answer. Find
// also walks up the parent chain, with one table read and one splitting
// write per hop through the single read/write table port pair.
// The result sits in an output register, so the next request is taken
// while it waits; if the receiver stalls and that register is full, a
// finished result is parked and input stalls until it moves out.
// After reset the table is swept to identity, one entry a cycle, and
// in_stall stays high during the sweep.
// ---------------------------------------------------------------------------
module union_find_collapse_map #(
  parameter int NUM_VERTICES = ufcm_pkg::NUM_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ufcm_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output ufcm_pkg::out_req_t out_req
);

  localparam int AW = $clog2(NUM_VERTICES);
  localparam int HW = $clog2(2 * NUM_VERTICES + 1);
  localparam logic [HW-1:0] HOP_LIMIT  = HW'(2 * NUM_VERTICES);
  localparam logic [AW-1:0] CLEAR_LAST = AW'(NUM_VERTICES - 1);

  ufcm_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]                   clr_r, clr_nxt;
  logic [ufcm_pkg::OPCODE_W-1:0]   op_r, op_nxt;
  ufcm_pkg::vertex_t               a_r, a_nxt;
  ufcm_pkg::vertex_t               b_r, b_nxt;
  ufcm_pkg::vertex_t               cur_r, cur_nxt;
  ufcm_pkg::vertex_t               p_r, p_nxt;
  logic [HW-1:0]                   hops_r, hops_nxt;
  logic                            own_r, own_nxt;
  ufcm_pkg::vertex_t               res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ufcm_pkg::out_req_t              out_req_r, out_req_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  ufcm_pkg::vertex_t ram_wdata;
  logic [AW-1:0]     ram_raddr;
  ufcm_pkg::vertex_t ram_rdata;

  logic              in_acc;
  logic              out_free;
  ufcm_pkg::vertex_t p0;
  logic              own0;
  ufcm_pkg::vertex_t g;
  logic [HW-1:0]     hops_inc;
  logic              fin_first;
  logic              fin_walk;
  ufcm_pkg::vertex_t first_res;
  logic [31:0]       clr_wide;

  // vertices past the table are their own parent and take no writes
  function automatic logic in_range(input ufcm_pkg::vertex_t v);
    in_range = (32'(v) < NUM_VERTICES);
  endfunction

  function automatic logic [AW-1:0] addr_of(input ufcm_pkg::vertex_t v);
    logic [31:0] wide;
    wide    = 32'(v);
    addr_of = wide[AW-1:0];
  endfunction

  ufcm_ram #(
    .DEPTH (NUM_VERTICES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != ufcm_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  assign p0        = in_range(a_r) ? ram_rdata : a_r;
  assign own0      = (p0 == a_r);
  assign g         = in_range(p_r) ? ram_rdata : p_r;
  assign hops_inc  = hops_r + HW'(1);
  assign fin_first = (op_r != ufcm_pkg::OP_FIND) || own0;
  assign fin_walk  = (g == p_r) || (hops_inc == HOP_LIMIT);
  assign clr_wide  = 32'(clr_r);

  always_comb begin
    unique case (op_r)
      ufcm_pkg::OP_FIND: first_res = a_r;
      ufcm_pkg::OP_LINK: first_res = a_r;
      default:           first_res = p0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ufcm_pkg::ST_CLEAR: begin
        if (clr_r == CLEAR_LAST) state_nxt = ufcm_pkg::ST_IDLE;
      end
      ufcm_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = ufcm_pkg::ST_FIRST;
      end
      ufcm_pkg::ST_FIRST: begin
        if (!fin_first) state_nxt = ufcm_pkg::ST_WALK;
        else if (out_free) state_nxt = ufcm_pkg::ST_IDLE;
        else state_nxt = ufcm_pkg::ST_HOLD;
      end
      ufcm_pkg::ST_WALK: begin
        if (fin_walk) begin
          state_nxt = out_free ? ufcm_pkg::ST_IDLE : ufcm_pkg::ST_HOLD;
        end
      end
      ufcm_pkg::ST_HOLD: begin
        if (out_free) state_nxt = ufcm_pkg::ST_IDLE;
      end
      default: state_nxt = ufcm_pkg::ST_CLEAR;
    endcase
  end

  // datapath, table port and output register
  always_comb begin
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cur_nxt       = cur_r;
    p_nxt         = p_r;
    hops_nxt      = hops_r;
    own_nxt       = own_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_req_nxt   = out_req_r;
    ram_we        = 1'b0;
    ram_waddr     = addr_of(cur_r);
    ram_wdata     = g;
    ram_raddr     = addr_of(in_req.vertex_a);
    unique case (state_r)
      ufcm_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = clr_wide[ufcm_pkg::VERTEX_W-1:0];
        clr_nxt   = clr_r + AW'(1);
      end
      ufcm_pkg::ST_IDLE: begin
        if (in_acc) begin
          op_nxt = in_req.opcode;
          a_nxt  = in_req.vertex_a;
          b_nxt  = in_req.vertex_b;
        end
      end
      ufcm_pkg::ST_FIRST: begin
        ram_raddr = addr_of(p0);
        if (op_r == ufcm_pkg::OP_LINK) begin
          ram_we    = in_range(b_r);
          ram_waddr = addr_of(b_r);
          ram_wdata = a_r;
        end
        cur_nxt  = a_r;
        p_nxt    = p0;
        hops_nxt = '0;
        own_nxt  = own0;
        if (fin_first) begin
          res_nxt = first_res;
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_req_nxt   = '{result_vertex: first_res, is_own_root: own0};
          end
        end
      end
      ufcm_pkg::ST_WALK: begin
        // split: point the current entry at its grandparent, step up one
        ram_raddr = addr_of(g);
        ram_we    = in_range(cur_r);
        cur_nxt   = p_r;
        p_nxt     = g;
        hops_nxt  = hops_inc;
        if (fin_walk) begin
          res_nxt = p_r;
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_req_nxt   = '{result_vertex: p_r, is_own_root: own_r};
          end
        end
      end
      ufcm_pkg::ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_req_nxt   = '{result_vertex: res_r, is_own_root: own_r};
        end
      end
      default: begin
        clr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ufcm_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    cur_r     <= cur_nxt;
    p_r       <= p_nxt;
    hops_r    <= hops_nxt;
    own_r     <= own_nxt;
    res_r     <= res_nxt;
    out_req_r <= out_req_nxt;
  end

endmodule

[rtl/ufcm_ram.sv]
// ---------------------------------------------------------------------------
// ufcm_ram
// Parent table storage: one write port, one read port, registered read
// data. A read of the entry written in the same cycle returns the new data.
// ---------------------------------------------------------------------------
module ufcm_ram #(
  parameter int DEPTH = ufcm_pkg::NUM_VERTICES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  ufcm_pkg::vertex_t wdata,
  input  logic [AW-1:0]     raddr,
  output ufcm_pkg::vertex_t rdata
);

  ufcm_pkg::vertex_t mem [DEPTH];
  ufcm_pkg::vertex_t mem_q_r;
  ufcm_pkg::vertex_t byp_data_r;
  logic              byp_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_q_r    <= mem[raddr];
    byp_r      <= we && (waddr == raddr);
    byp_data_r <= wdata;
  end

  assign rdata = byp_r ? byp_data_r : mem_q_r;

endmodule

[sim/tb_union_find_collapse_map.sv]
// ---------------------------------------------------------------------------
// tb_union_find_collapse_map
// Self-checking bench for the union-find parent table. A short table of
// hand-picked requests (edges of the vertex range, every opcode, self links,
// chains and link cycles) is followed by random requests: mostly forests
// grown in a small window of vertices plus chain builds ended by a find.
// Every accepted request is run through a shadow parent table, and each
// result is compared against the oldest pending prediction. Both sides
// idle at random. The receiver holds off once for a long stretch, and the
// sender drains once.
// ---------------------------------------------------------------------------
module tb_union_find_collapse_map;

  localparam int          NUM_V            = ufcm_pkg::NUM_VERTICES_DEF;
  localparam logic [ufcm_pkg::OPCODE_W-1:0] OP_SPARE = 2'd3;
  localparam int          TOTAL_REQS       = 1450;
  localparam int          LONG_HOLD_AT     = 300;
  localparam int          LONG_HOLD_CYCLES = 120;
  localparam int          PAUSE_AT         = 700;
  localparam int          DRAIN_CYCLES     = 20;
  localparam int unsigned CYCLE_LIMIT      = 12000000;
  localparam int          DIR_ROWS         = 25;
  localparam int          EXP_DEPTH        = 16;

  typedef struct packed {
    ufcm_pkg::in_req_t  req;
    logic               typed;
    ufcm_pkg::out_req_t want;
  } dir_row_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  ufcm_pkg::in_req_t  in_req    = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ufcm_pkg::out_req_t out_req;

  ufcm_pkg::vertex_t  parent_shadow [NUM_V];
  ufcm_pkg::out_req_t exp_fifo [EXP_DEPTH];
  int                 exp_wr      = 0;
  int                 exp_rd      = 0;
  int                 n_sent      = 0;
  int                 n_results   = 0;
  int                 err_count   = 0;
  int unsigned        cycle_count = 0;

  // columns: opcode, vertex_a, vertex_b, typed, want result_vertex, want is_own_root
  dir_row_t dir_rows [DIR_ROWS] = '{
    {ufcm_pkg::OP_FIND,   10'd0,    10'd1023, 1'b1, 10'd0,    1'b1},
    {ufcm_pkg::OP_FIND,   10'd1023, 10'd0,    1'b1, 10'd1023, 1'b1},
    {ufcm_pkg::OP_LOOKUP, 10'd682,  10'd341,  1'b1, 10'd682,  1'b1},
    {OP_SPARE,            10'd341,  10'd682,  1'b1, 10'd341,  1'b1},
    {ufcm_pkg::OP_LINK,   10'd1023, 10'd0,    1'b1, 10'd1023, 1'b1},
    {ufcm_pkg::OP_LOOKUP, 10'd0,    10'd1023, 1'b1, 10'd1023, 1'b0},
    {ufcm_pkg::OP_FIND,   10'd0,    10'd1023, 1'b1, 10'd1023, 1'b0},
    {ufcm_pkg::OP_LINK,   10'd0,    10'd1023, 1'b1, 10'd0,    1'b0},
    {ufcm_pkg::OP_FIND,   10'd1023, 10'd682,  1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_LOOKUP, 10'd0,    10'd341,  1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_LINK,   10'd5,    10'd5,    1'b1, 10'd5,    1'b1},
    {ufcm_pkg::OP_LINK,   10'd2,    10'd1,    1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_LINK,   10'd3,    10'd2,    1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_LINK,   10'd4,    10'd3,    1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_LINK,   10'd341,  10'd4,    1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_FIND,   10'd1,    10'd1023, 1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_LOOKUP, 10'd1,    10'd0,    1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_LINK,   10'd8,    10'd7,    1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_LINK,   10'd9,    10'd8,    1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_LINK,   10'd7,    10'd9,    1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_FIND,   10'd7,    10'd0,    1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_FIND,   10'd8,    10'd682,  1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_LINK,   10'd682,  10'd1022, 1'b0, 10'd0,    1'b0},
    {OP_SPARE,            10'd1022, 10'd341,  1'b0, 10'd0,    1'b0},
    {ufcm_pkg::OP_FIND,   10'd1022, 10'd1023, 1'b0, 10'd0,    1'b0}
  };

  union_find_collapse_map DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               exp_wr - exp_rd);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    err_count++;
  endtask

  // applies one request to the shadow table and returns the answer it gives
  function automatic ufcm_pkg::out_req_t apply_request(input ufcm_pkg::in_req_t r);
    ufcm_pkg::out_req_t o;
    ufcm_pkg::vertex_t  cur;
    ufcm_pkg::vertex_t  up;
    int                 hops;
    o.is_own_root = (parent_shadow[r.vertex_a] == r.vertex_a);
    case (r.opcode)
      ufcm_pkg::OP_FIND: begin
        cur  = r.vertex_a;
        hops = 0;
        // path splitting, walk bounded so a link cycle still ends
        while (parent_shadow[cur] != cur && hops < 2 * NUM_V) begin
          up                 = parent_shadow[cur];
          parent_shadow[cur] = parent_shadow[up];
          cur                = up;
          hops++;
        end
        o.result_vertex = cur;
      end
      ufcm_pkg::OP_LINK: begin
        parent_shadow[r.vertex_b] = r.vertex_a;
        o.result_vertex           = r.vertex_a;
      end
      default: begin
        // the spare opcode answers like lookup
        o.result_vertex = parent_shadow[r.vertex_a];
      end
    endcase
    return o;
  endfunction

  task automatic send_req(input ufcm_pkg::in_req_t r, input logic typed,
                          input ufcm_pkg::out_req_t typed_want);
    int                 gap;
    ufcm_pkg::out_req_t pred;
    gap = ((n_sent / 150) % 4 == 2) ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pred = apply_request(r);
    exp_fifo[exp_wr % EXP_DEPTH] = typed ? typed_want : pred;
    exp_wr++;
    n_sent++;
  endtask

  // result side: random stall per result, one long hold-off
  int   rx_gap         = 0;
  int   hold_left      = 0;
  logic long_hold_done = 1'b0;

  always @(posedge clk) begin : rx_side
    ufcm_pkg::out_req_t want;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        n_results++;
        if (exp_wr == exp_rd) begin
          note_mismatch("result with nothing pending, result_vertex",
                        int'(out_req.result_vertex), -1);
        end else begin
          want = exp_fifo[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (out_req.result_vertex !== want.result_vertex)
            note_mismatch("result_vertex", int'(out_req.result_vertex),
                          int'(want.result_vertex));
          if (out_req.is_own_root !== want.is_own_root)
            note_mismatch("is_own_root", int'(out_req.is_own_root),
                          int'(want.is_own_root));
        end
        rx_gap = ((n_results / 150) % 4 == 1) ? 0 : $urandom_range(0, 4);
      end
      if (!long_hold_done && n_sent >= LONG_HOLD_AT) begin
        hold_left      = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= (rx_gap > 0);
        if (rx_gap > 0) rx_gap--;
      end
    end
  end

  initial begin
    ufcm_pkg::in_req_t r;
    ufcm_pkg::vertex_t base;
    ufcm_pkg::vertex_t pool_base;
    ufcm_pkg::vertex_t a;
    ufcm_pkg::vertex_t b;
    int                len;
    int                pick;
    logic              paused;
    paused = 1'b0;
    for (int v = 0; v < NUM_V; v++) parent_shadow[v] = ufcm_pkg::vertex_t'(v);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    pool_base = ufcm_pkg::vertex_t'($urandom);
    while (n_sent < TOTAL_REQS) begin
      if ($urandom_range(0, 63) == 0) pool_base = ufcm_pkg::vertex_t'($urandom);
      if ($urandom_range(0, 99) < 15) begin
        // grow a chain bottom-up, then find from its bottom
        len  = $urandom_range(2, 24);
        base = $urandom_range(0, 1) ? pool_base : ufcm_pkg::vertex_t'($urandom);
        for (int k = 0; k < len; k++) begin
          r.opcode   = ufcm_pkg::OP_LINK;
          r.vertex_a = base + ufcm_pkg::vertex_t'(k + 1);
          r.vertex_b = base + ufcm_pkg::vertex_t'(k);
          send_req(r, 1'b0, '0);
        end
        r.opcode   = ufcm_pkg::OP_FIND;
        r.vertex_a = base;
        r.vertex_b = ufcm_pkg::vertex_t'($urandom);
        send_req(r, 1'b0, '0);
      end else begin
        pick = $urandom_range(0, 99);
        a = ($urandom_range(0, 9) < 7)
            ? pool_base + ufcm_pkg::vertex_t'($urandom_range(0, 15))
            : ufcm_pkg::vertex_t'($urandom);
        b = ($urandom_range(0, 9) < 7)
            ? pool_base + ufcm_pkg::vertex_t'($urandom_range(0, 15))
            : ufcm_pkg::vertex_t'($urandom);
        r.opcode   = (pick < 40) ? ufcm_pkg::OP_FIND : (pick < 70) ? ufcm_pkg::OP_LINK :
                     (pick < 92) ? ufcm_pkg::OP_LOOKUP : OP_SPARE;
        r.vertex_a = a;
        r.vertex_b = b;
        send_req(r, 1'b0, '0);
      end
      if (!paused && n_sent >= PAUSE_AT) begin
        // let the block run dry before going on
        paused = 1'b1;
        in_valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && exp_wr == exp_rd) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
